// ===== rtl/core/ugl_pkg.sv =====
// Shared types and constants for the uniform grid linear resampler.
`default_nettype none
package ugl_pkg;

  localparam int unsigned DefKernelDepth = 64;
  localparam int unsigned DefMaxOutputs  = 64;
  localparam int unsigned StepW          = 31;
  localparam int unsigned FracW          = 16;
  localparam logic [StepW-1:0] StepReset = 31'd65536;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SHORT = 2'd1,
    STAT_TRUNC = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               last_result;
    status_e            status;
  } result_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_RD_FIRST,
    S_RD_LAST,
    S_SET,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_BEST_RD,
    S_BEST_CHK,
    S_NB_RD,
    S_NB_CAP,
    S_PREP,
    S_DIV,
    S_MUL,
    S_SUM,
    S_OUT
  } state_e;

  typedef struct packed {
    logic        start;
    logic [32:0] num;
    logic [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [FracW-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/uniform_grid_linear_resampler_top.sv =====
// Top level: point loading, grid sequencer, nearest search and interpolation.
//
//  channel  | direction | handshake            | payload
//  in       | input     | in_valid_i/in_stall_o | point_t  (point_x, point_y, last_point)
//  out      | output    | out_valid_o/out_stall_i | result_t (out_x, out_y, last_result, status)
//  cfg      | input     | cfg_we_i             | cfg_data_i (grid_step)
//
// A point without the last mark is stored and the input stays ready. The marked point starts
// a run with setup states S_RD_FIRST, S_RD_LAST and S_SET; each grid sample then scans the N
// stored points through the single memory read port, reads the nearest point and its neighbor,
// forms the product, using the divider when the fraction needs it, and presents the result. The
// input stalls for the whole run. An output stall holds the result register and the sequencer.
// Reset clears control state; the point memory is not cleared.
`default_nettype none
module uniform_grid_linear_resampler_top import ugl_pkg::*; #(
  parameter int unsigned KERNEL_DEPTH = DefKernelDepth,
  parameter int unsigned MAX_OUTPUTS  = DefMaxOutputs
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire point_t           in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output result_t               out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [StepW-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(KERNEL_DEPTH);
  localparam int unsigned CW = $clog2(KERNEL_DEPTH + 1);
  localparam int unsigned KW = $clog2(MAX_OUTPUTS + 1);

  state_e state_q, state_d;

  logic [StepW-1:0]   step_q;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      best_q, best_d;
  logic [32:0]        bd_q, bd_d;
  logic [KW-1:0]      k_q, k_d;
  logic signed [31:0] gx_q, gx_d;
  logic signed [31:0] x0_q, x0_d, xl_q, xl_d;
  logic signed [31:0] x1_q, x1_d, y1_q, y1_d, x2_q, x2_d, y2_q, y2_d;
  logic               dir_q, dir_d;
  logic [CW-1:0]      nb_q, nb_d;
  logic [16:0]        mu_q, mu_d;
  logic signed [32:0] dy_q, dy_d;
  logic [49:0]        prod_q, prod_d;
  result_t            res_q, res_d;

  logic               accept;
  logic               load_out;
  logic signed [31:0] y_res;
  logic               short_res;
  logic [AW-1:0]      raddr;
  logic signed [31:0] rx, ry;
  logic signed [32:0] dx;
  logic [32:0]        dmag;
  logic signed [32:0] pd, pn;
  logic [32:0]        pdm, pnm;
  logic [33:0]        delta;
  logic signed [33:0] next_gx;
  logic               past_end, at_max, fin, trunc;
  div_req_t           dreq;
  div_rsp_t           drsp;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_LOAD);

  ugl_store #(.KERNEL_DEPTH(KERNEL_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && (cnt_q < CW'(KERNEL_DEPTH))),
    .waddr_i (cnt_q[AW-1:0]),
    .wx_i    (in_data_i.point_x),
    .wy_i    (in_data_i.point_y),
    .raddr_i (raddr),
    .rx_o    (rx),
    .ry_o    (ry)
  );

  ugl_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  // Read address per state
  always_comb begin
    case (state_q)
      S_RD_LAST: raddr = AW'(cnt_q - CW'(1));
      S_SRCH_RD: raddr = idx_q[AW-1:0];
      S_BEST_RD: raddr = best_q[AW-1:0];
      S_NB_RD:   raddr = nb_q[AW-1:0];
      default:   raddr = '0;
    endcase
  end

  always_comb begin
    dx       = 33'(rx) - 33'(gx_q);
    dmag     = dx[32] ? 33'(-dx) : dx;
    pd       = 33'(x2_q) - 33'(x1_q);
    pn       = 33'(gx_q) - 33'(x1_q);
    pdm      = pd[32] ? 33'(-pd) : pd;
    pnm      = pn[32] ? 33'(-pn) : pn;
    delta    = prod_q[49:16];
    next_gx  = 34'(gx_q) + 34'({1'b0, step_q});
    past_end = (step_q != '0) && (next_gx > 34'(xl_q));
    at_max   = ((k_q + KW'(1)) == KW'(MAX_OUTPUTS));
    fin      = at_max || past_end;
    trunc    = at_max && !past_end;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: begin
        if (accept && in_data_i.last_point) begin
          if (cnt_d < CW'(2)) state_d = S_OUT;
          else                state_d = S_RD_FIRST;
        end
      end
      S_RD_FIRST: state_d = S_RD_LAST;
      S_RD_LAST:  state_d = S_SET;
      S_SET:      state_d = S_SRCH_RD;
      S_SRCH_RD:  state_d = S_SRCH_CMP;
      S_SRCH_CMP: state_d = (idx_q == cnt_q - CW'(1)) ? S_BEST_RD : S_SRCH_RD;
      S_BEST_RD:  state_d = S_BEST_CHK;
      S_BEST_CHK: begin
        if (rx == gx_q) state_d = S_OUT;
        else if (rx < gx_q)
          state_d = (best_q + CW'(1) < cnt_q) ? S_NB_RD : S_OUT;
        else
          state_d = (best_q != '0) ? S_NB_RD : S_OUT;
      end
      S_NB_RD:  state_d = S_NB_CAP;
      S_NB_CAP: state_d = S_PREP;
      S_PREP: begin
        if (pd == '0 || pn == '0 || pd[32] != pn[32] || pnm >= pdm) state_d = S_MUL;
        else state_d = S_DIV;
      end
      S_DIV: if (drsp.done) state_d = S_MUL;
      S_MUL: state_d = S_SUM;
      S_SUM: state_d = S_OUT;
      S_OUT: begin
        if (!out_stall_i) state_d = res_q.last_result ? S_LOAD : S_SRCH_RD;
      end
      default: state_d = S_LOAD;
    endcase
  end

  // Datapath updates
  always_comb begin
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    best_d    = best_q;
    bd_d      = bd_q;
    k_d       = k_q;
    gx_d      = gx_q;
    x0_d      = x0_q;
    xl_d      = xl_q;
    x1_d      = x1_q;
    y1_d      = y1_q;
    x2_d      = x2_q;
    y2_d      = y2_q;
    dir_d     = dir_q;
    nb_d      = nb_q;
    mu_d      = mu_q;
    dy_d      = dy_q;
    prod_d    = prod_q;
    load_out  = 1'b0;
    short_res = 1'b0;
    y_res     = ry;
    dreq      = '{start: 1'b0, num: pnm, den: pdm};
    case (state_q)
      S_LOAD: begin
        if (accept) begin
          if (cnt_q < CW'(KERNEL_DEPTH)) cnt_d = cnt_q + CW'(1);
          if (in_data_i.last_point && (cnt_d < CW'(2))) begin
            load_out  = 1'b1;
            short_res = 1'b1;
            cnt_d     = '0;
          end
        end
      end
      S_RD_LAST: x0_d = rx;
      S_SET: begin
        xl_d  = rx;
        gx_d  = x0_q;
        k_d   = '0;
        idx_d = '0;
      end
      S_SRCH_CMP: begin
        // Later points win ties
        if (idx_q == '0 || dmag <= bd_q) begin
          bd_d   = dmag;
          best_d = idx_q;
        end
        idx_d = idx_q + CW'(1);
      end
      S_BEST_CHK: begin
        if (rx == gx_q) begin
          load_out = 1'b1;
        end else if (rx < gx_q) begin
          x1_d  = rx;
          y1_d  = ry;
          dir_d = 1'b1;
          nb_d  = best_q + CW'(1);
          if (!(best_q + CW'(1) < cnt_q)) load_out = 1'b1;
        end else begin
          x2_d  = rx;
          y2_d  = ry;
          dir_d = 1'b0;
          nb_d  = best_q - CW'(1);
          if (best_q == '0) load_out = 1'b1;
        end
      end
      S_NB_CAP: begin
        if (dir_q) begin
          x2_d = rx;
          y2_d = ry;
        end else begin
          x1_d = rx;
          y1_d = ry;
        end
      end
      S_PREP: begin
        dy_d = 33'(y2_q) - 33'(y1_q);
        if (pd == '0 || pn == '0 || pd[32] != pn[32]) mu_d = '0;
        else if (pnm >= pdm) mu_d = 17'd65536;
        else dreq.start = 1'b1;
      end
      S_DIV: if (drsp.done) mu_d = {1'b0, drsp.quo};
      S_MUL: prod_d = 50'((dy_q[32] ? 33'(-dy_q) : dy_q) * 50'(mu_q));
      S_SUM: begin
        y_res    = dy_q[32] ? 32'(34'(y1_q) - delta) : 32'(34'(y1_q) + delta);
        load_out = 1'b1;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (res_q.last_result) begin
            cnt_d = '0;
          end else begin
            gx_d  = 32'(next_gx);
            k_d   = k_q + KW'(1);
            idx_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register contents
  always_comb begin
    res_d = res_q;
    if (load_out) begin
      if (short_res) begin
        res_d = '{out_x: '0, out_y: '0, last_result: 1'b1, status: STAT_SHORT};
      end else begin
        res_d.out_x       = gx_q;
        res_d.out_y       = y_res;
        res_d.last_result = fin;
        res_d.status      = trunc ? STAT_TRUNC : STAT_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      step_q  <= StepReset;
      cnt_q   <= '0;
      idx_q   <= '0;
      best_q  <= '0;
      k_q     <= '0;
      dir_q   <= 1'b0;
      nb_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) step_q <= cfg_data_i;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      best_q  <= best_d;
      k_q     <= k_d;
      dir_q   <= dir_d;
      nb_q    <= nb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bd_q   <= bd_d;
    gx_q   <= gx_d;
    x0_q   <= x0_d;
    xl_q   <= xl_d;
    x1_q   <= x1_d;
    y1_q   <= y1_d;
    x2_q   <= x2_d;
    y2_q   <= y2_d;
    mu_q   <= mu_d;
    dy_q   <= dy_d;
    prod_q <= prod_d;
    res_q  <= res_d;
  end

  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = res_q;

endmodule
`default_nettype wire

// ===== rtl/core/ugl_store.sv =====
// Point memory: x and y arrays, one write and one registered read per cycle.
`default_nettype none
module ugl_store import ugl_pkg::*; #(
  parameter int unsigned KERNEL_DEPTH = DefKernelDepth
) (
  input  wire logic                            clk_i,
  input  wire logic                            we_i,
  input  wire logic [$clog2(KERNEL_DEPTH)-1:0] waddr_i,
  input  wire logic signed [31:0]              wx_i,
  input  wire logic signed [31:0]              wy_i,
  input  wire logic [$clog2(KERNEL_DEPTH)-1:0] raddr_i,
  output logic signed [31:0]                   rx_o,
  output logic signed [31:0]                   ry_o
);

  logic signed [31:0] x_mem [KERNEL_DEPTH];
  logic signed [31:0] y_mem [KERNEL_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      x_mem[waddr_i] <= wx_i;
      y_mem[waddr_i] <= wy_i;
    end
    rx_o <= x_mem[raddr_i];
    ry_o <= y_mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/core/ugl_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the Q0.16 fraction.
`default_nettype none
module ugl_divider import ugl_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic [33:0]        rem_q, rem_d;
  logic [FracW-1:0]   quo_q, quo_d;
  logic [4:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [33:0]        shifted;

  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[32:0], 1'b0};
    if (req_i.start) begin
      rem_d  = {1'b0, req_i.num};
      cnt_d  = 5'(FracW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, req_i.den}) begin
        rem_d = shifted - {1'b0, req_i.den};
        quo_d = {quo_q[FracW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[FracW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule
`default_nettype wire

// ===== rtl/core/ugl_checker.sv =====
// Port-level checks for the resampler, bound to the top level.
`default_nettype none
module ugl_checker import ugl_pkg::*; (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    in_stall_o,
  input wire logic    out_valid_o,
  input wire logic    out_stall_i,
  input wire result_t out_data_o
);

  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped under stall");

  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STAT_TRUNC |-> out_data_o.last_result)
    else $error("truncation flag on non-final result");

  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STAT_SHORT |->
      out_data_o.last_result && out_data_o.out_x == '0 && out_data_o.out_y == '0)
    else $error("bad too-short result");

endmodule

bind uniform_grid_linear_resampler_top ugl_checker u_ugl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
